@@ sv/ata_pkg.sv @@
// Shared types and constants for the ATA task-file setup block.
// No dependencies; every other file in sv/ imports this package.
package ata_pkg;

  // Request and result payloads
  typedef struct packed {
    logic [47:0] block_address;
    logic [8:0]  sector_count;
    logic        is_write;
  } req_t;

  typedef struct packed {
    logic [3:0] reg_select;
    logic [7:0] reg_value;
    logic       status;
    logic       last;
  } wr_t;

  // Prepared run of register writes, handed from preparation to sequencer
  typedef struct packed {
    logic            bad;
    logic            ext;
    logic [7:0]      count;
    logic [7:0]      devsel;
    logic [7:0]      cmd;
    logic [5:0][7:0] lba;
  } job_t;

  // Divide-by-63 unit status and results
  typedef struct packed {
    logic        busy;
    logic [5:0]  rem;
    logic [19:0] quot;
  } chs_t;

  // Configuration register indexes
  localparam logic [0:0] CFG_DRIVE_SLAVE = 1'd0;
  localparam logic [0:0] CFG_HAS_LBA     = 1'd1;

  // Task-file register selects
  localparam logic [3:0] SEL_DEVSEL   = 4'd0;
  localparam logic [3:0] SEL_FEATURES = 4'd1;
  localparam logic [3:0] SEL_COUNT_HI = 4'd2;
  localparam logic [3:0] SEL_LBA3     = 4'd3;
  localparam logic [3:0] SEL_LBA4     = 4'd4;
  localparam logic [3:0] SEL_LBA5     = 4'd5;
  localparam logic [3:0] SEL_COUNT_LO = 4'd6;
  localparam logic [3:0] SEL_LBA0     = 4'd7;
  localparam logic [3:0] SEL_LBA1     = 4'd8;
  localparam logic [3:0] SEL_LBA2     = 4'd9;
  localparam logic [3:0] SEL_COMMAND  = 4'd10;

  // Device-select bases and command opcodes
  localparam logic [7:0] DEVSEL_LBA        = 8'hE0;
  localparam logic [7:0] DEVSEL_CHS        = 8'hA0;
  localparam logic [7:0] CMD_READ_PIO      = 8'h20;
  localparam logic [7:0] CMD_READ_PIO_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE_PIO     = 8'h30;
  localparam logic [7:0] CMD_WRITE_PIO_EXT = 8'h34;

  // CHS geometry: 63 sectors per track, one base-64 digit per divider step
  localparam int         ADDR_W     = 48;
  localparam int         DIGIT_W    = 6;
  localparam int         DIV_STEPS  = ADDR_W / DIGIT_W;
  localparam int         STEP_W     = $clog2(DIV_STEPS);
  localparam logic [6:0] CHS_SPT    = 7'd63;

endpackage

@@ sv/ata_chs_div.sv @@
// Iterative divide-by-63 of the 48-bit block address, one base-64 digit a cycle.
// Depends on ata_pkg.
module ata_chs_div import ata_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  output chs_t              res
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [ADDR_W-1:0] shift;
  logic [5:0]        rem;
  logic [19:0]       quot;

  logic [11:0] v;
  logic [5:0]  q0;
  logic [6:0]  r1;
  logic        fix;
  logic [5:0]  digit;
  logic [5:0]  rem_next;

  // One digit of long division: 64 = 63 + 1, so the partial remainder is
  // low digit plus estimate, corrected by at most one subtraction
  always_comb begin
    v        = {rem, shift[ADDR_W-1 -: DIGIT_W]};
    q0       = v[11:6];
    r1       = {1'b0, v[5:0]} + {1'b0, q0};
    fix      = (r1 >= CHS_SPT);
    digit    = fix ? q0 + 6'd1 : q0;
    rem_next = fix ? 6'(r1 - CHS_SPT) : r1[5:0];
  end

  // Control: run a fixed number of steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == STEP_W'(DIV_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  // Datapath: shift digits in, keep the low quotient bits only
  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
      quot  <= '0;
      cnt   <= '0;
    end else if (busy) begin
      shift <= {shift[ADDR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem   <= rem_next;
      quot  <= {quot[19-DIGIT_W:0], digit};
      cnt   <= cnt + STEP_W'(1);
    end
  end

  assign res = '{busy: busy, rem: rem, quot: quot};

endmodule

@@ sv/ata_prep.sv @@
// Request register and run preparation: mode choice, byte split, CHS mapping.
// Depends on ata_pkg and ata_chs_div.
module ata_prep import ata_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic drive_slave,
  input  logic device_has_lba,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic job_valid,
  input  logic job_take,
  output job_t job
);

  logic held;
  req_t item;
  chs_t chs;
  logic accept;
  logic in_bad;

  logic [7:0] head;
  logic [7:0] base;

  assign in_ready = !held;
  assign accept   = in_valid && !held;
  assign in_bad   = in_data.sector_count[8] || (in_data.sector_count == '0);

  // Hold one request until the sequencer takes its run
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (job_take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  // Start the divider only for a good request on a CHS device
  ata_chs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !device_has_lba && !in_bad),
    .dividend (in_data.block_address),
    .res      (chs)
  );

  assign job_valid = held && !chs.busy;

  // Build the run from the held request
  always_comb begin
    job.bad   = item.sector_count[8] || (item.sector_count == '0);
    job.ext   = device_has_lba && (item.block_address[47:28] != '0);
    job.count = item.sector_count[7:0];
    job.lba   = '0;
    head      = '0;
    base      = DEVSEL_LBA;
    if (job.ext) begin
      for (int i = 0; i < 6; i++) begin
        job.lba[i] = item.block_address[i*8 +: 8];
      end
      job.cmd = item.is_write ? CMD_WRITE_PIO_EXT : CMD_READ_PIO_EXT;
    end else if (device_has_lba) begin
      job.lba[0] = item.block_address[7:0];
      job.lba[1] = item.block_address[15:8];
      job.lba[2] = item.block_address[23:16];
      head       = {4'd0, item.block_address[27:24]};
      job.cmd    = item.is_write ? CMD_WRITE_PIO : CMD_READ_PIO;
    end else begin
      // sector is remainder plus one; quotient low nibble is the head,
      // the rest the cylinder
      job.lba[0] = {2'b00, chs.rem} + 8'd1;
      job.lba[1] = chs.quot[11:4];
      job.lba[2] = chs.quot[19:12];
      head       = {4'd0, chs.quot[3:0]};
      base       = DEVSEL_CHS;
      job.cmd    = item.is_write ? CMD_WRITE_PIO : CMD_READ_PIO;
    end
    job.devsel = base | {3'd0, drive_slave, 4'd0} | head;
  end

endmodule

@@ sv/ata_seq.sv @@
// Register-write sequencer with output register; walks the task-file selects.
// Depends on ata_pkg.
module ata_seq import ata_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_take,
  input  job_t job_in,
  output logic out_valid,
  input  logic out_ready,
  output wr_t  out_data
);

  logic       active;
  job_t       job;
  logic [3:0] sel;
  logic [3:0] sel_next;
  logic [7:0] value;
  logic       emit;
  logic       is_last;
  wr_t        wr;

  // Pick the byte for the current register
  always_comb begin
    case (sel)
      SEL_DEVSEL:   value = job.devsel;
      SEL_FEATURES: value = 8'd0;
      SEL_COUNT_HI: value = 8'd0;
      SEL_LBA3:     value = job.lba[3];
      SEL_LBA4:     value = job.lba[4];
      SEL_LBA5:     value = job.lba[5];
      SEL_COUNT_LO: value = job.count;
      SEL_LBA0:     value = job.lba[0];
      SEL_LBA1:     value = job.lba[1];
      SEL_LBA2:     value = job.lba[2];
      SEL_COMMAND:  value = job.cmd;
      default:      value = 8'd0;
    endcase
  end

  // Skip the high-order writes unless in LBA48 mode
  always_comb begin
    if (sel == SEL_FEATURES && !job.ext) begin
      sel_next = SEL_COUNT_LO;
    end else begin
      sel_next = sel + 4'd1;
    end
  end

  always_comb begin
    is_last = job.bad || (sel == SEL_COMMAND);
    if (job.bad) begin
      wr = '{reg_select: SEL_DEVSEL, reg_value: 8'd0, status: 1'b1, last: 1'b1};
    end else begin
      wr = '{reg_select: sel, reg_value: value, status: 1'b0, last: is_last};
    end
  end

  assign emit     = active && (!out_valid || out_ready);
  assign job_take = job_valid && (!active || (emit && is_last));

  // Control: run activity and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_take) begin
        active <= 1'b1;
      end else if (emit && is_last) begin
        active <= 1'b0;
      end
    end
  end

  // Datapath: load run, advance select, register each write
  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= job_in;
      sel <= SEL_DEVSEL;
    end else if (emit) begin
      sel <= sel_next;
    end
    if (emit) begin
      out_data <= wr;
    end
  end

endmodule

@@ sv/ata_taskfile_setup.sv @@
// ATA task-file setup: turns a sector request into its run of register writes.
// Depends on ata_pkg, ata_prep, ata_chs_div and ata_seq.
// Path: a request is held in ata_prep, loaded into ata_seq, and each write registered at the output.
// Throughput: one write a cycle while out_ready allows; a request makes 11 (LBA48), 7 (LBA28)
// or a single (error) write, and CHS requests also wait for the 8-step divide-by-63 unit.
// Reset: synchronous; clears control, drive_slave to 0, device_has_lba to 1.
module ata_taskfile_setup import ata_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [0:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output wr_t        out_data
);

  logic drive_slave;
  logic device_has_lba;
  logic job_valid;
  logic job_take;
  job_t job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_slave    <= 1'b0;
      device_has_lba <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DRIVE_SLAVE: drive_slave    <= cfg_data[0];
        CFG_HAS_LBA:     device_has_lba <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  ata_prep u_prep (
    .clk            (clk),
    .rst            (rst),
    .drive_slave    (drive_slave),
    .device_has_lba (device_has_lba),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .job_valid      (job_valid),
    .job_take       (job_take),
    .job            (job)
  );

  ata_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job_in    (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An error result always ends its run
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.last)
    else $error("error result without last");

  // A good run ends on the command register
  a_last_command: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last && !out_data.status |-> out_data.reg_select == SEL_COMMAND)
    else $error("run ended on a register other than the command");

  // A taken write that is not last is followed by the next write of its run, never a new run start
  a_after_command: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last ##1 out_valid |->
      out_data.reg_select != SEL_DEVSEL)
    else $error("run restarted before its command");

endmodule

@@ tb/ata_taskfile_setup_tb.sv @@
// Self-checking testbench for ata_taskfile_setup: sector requests in, task-file writes out.
// Depends on ata_pkg for payload types, register indexes, selects and opcodes.
// Expected writes come from a predictor kept in step with the configuration registers.
module ata_taskfile_setup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ata_pkg::*;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_pace_t;

  typedef struct packed {
    logic slave;
    logic has_lba;
    req_t req;
    logic typed;
    wr_t  typed_write;
  } stim_row_t;

  localparam wr_t         BAD_COUNT_WRITE = '{SEL_DEVSEL, 8'h00, 1'b1, 1'b1};
  localparam logic [47:0] TRACK_SECTORS   = 48'd63;
  localparam logic [47:0] HEADS           = 48'd16;
  localparam int          NUM_DIRECTED    = 21;
  localparam int          NUM_PHASES      = 5;
  localparam int          PHASE_REQUESTS  = 40;
  localparam int          HOLD_CYCLES     = 80;
  localparam int          SETTLE_CYCLES   = 16;
  localparam int          TAIL_CYCLES     = 24;
  // Random phases, phase 0 in bit 0: (0,1) (1,0) (0,0) (1,1) (0,1) as (slave, lba)
  localparam logic [NUM_PHASES-1:0] PHASE_SLAVE = 5'b01010;
  localparam logic [NUM_PHASES-1:0] PHASE_LBA   = 5'b11001;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [0:0] cfg_index;
  logic [0:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  req_t       in_data;
  logic       out_valid;
  logic       out_ready;
  wr_t        out_data;

  // Shadow of the configuration registers and the writes still owed
  logic        slave_sel;
  logic        lba_capable;
  wr_t         pending_writes[$];
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  logic        long_hold_req = 1'b0;

  // Directed requests: extremes, bad counts, slave drive and CHS corner cases
  stim_row_t stim_table [NUM_DIRECTED] = '{
    '{1'b0, 1'b1, '{48'h0000_0000_0000, 9'd1,   1'b0}, 1'b0, '0},
    '{1'b0, 1'b1, '{48'h0000_0FFF_FFFF, 9'd255, 1'b1}, 1'b0, '0},
    '{1'b0, 1'b1, '{48'h0000_1000_0000, 9'd128, 1'b0}, 1'b0, '0},
    '{1'b0, 1'b1, '{48'hFFFF_FFFF_FFFF, 9'd255, 1'b1}, 1'b0, '0},
    '{1'b0, 1'b1, '{48'h0000_0000_1234, 9'd0,   1'b0}, 1'b1, BAD_COUNT_WRITE},
    '{1'b0, 1'b1, '{48'hFFFF_FFFF_FFFF, 9'd256, 1'b1}, 1'b1, BAD_COUNT_WRITE},
    '{1'b0, 1'b1, '{48'h0000_1000_0000, 9'd511, 1'b0}, 1'b1, BAD_COUNT_WRITE},
    '{1'b1, 1'b1, '{48'h0000_0ABC_DEF1, 9'd7,   1'b0}, 1'b0, '0},
    '{1'b1, 1'b1, '{48'h1234_5678_9ABC, 9'd200, 1'b1}, 1'b0, '0},
    '{1'b1, 1'b1, '{48'h0000_0000_0000, 9'd0,   1'b1}, 1'b1, BAD_COUNT_WRITE},
    '{1'b0, 1'b0, '{48'd0,              9'd1,   1'b0}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'd62,             9'd1,   1'b1}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'd63,             9'd2,   1'b0}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'd1007,           9'd3,   1'b1}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'd1008,           9'd4,   1'b0}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'd66060287,       9'd255, 1'b1}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'd66060288,       9'd64,  1'b0}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'hFFFF_FFFF_FFFF, 9'd255, 1'b1}, 1'b0, '0},
    '{1'b0, 1'b0, '{48'h0000_0000_0000, 9'd300, 1'b0}, 1'b1, BAD_COUNT_WRITE},
    '{1'b1, 1'b0, '{48'h0000_1000_0000, 9'd33,  1'b0}, 1'b0, '0},
    '{1'b1, 1'b0, '{48'h0000_0FFF_FFFF, 9'd255, 1'b1}, 1'b0, '0}
  };

  ata_taskfile_setup dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void push_write(logic [3:0] sel, logic [7:0] value, logic last);
    pending_writes.push_back('{reg_select: sel, reg_value: value, status: 1'b0, last: last});
  endfunction

  // Work out the task-file writes one request should produce
  function automatic void predict_taskfile_writes(req_t r);
    logic [47:0]     addr;
    logic [47:0]     track_no;
    logic [47:0]     sector_no;
    logic [47:0]     cylinder;
    logic [5:0][7:0] lba_bytes;
    logic [3:0]      head;
    logic [7:0]      dev_base;
    logic [7:0]      opcode;
    logic            ext;
    addr = r.block_address;
    if (r.sector_count == 9'd0 || r.sector_count > 9'd255) begin
      pending_writes.push_back(BAD_COUNT_WRITE);
      return;
    end
    lba_bytes = '0;
    ext = 1'b0;
    head = 4'd0;
    if (lba_capable && addr[47:28] != '0) begin
      ext = 1'b1;
      lba_bytes = addr;
      dev_base = DEVSEL_LBA;
      opcode = r.is_write ? CMD_WRITE_PIO_EXT : CMD_READ_PIO_EXT;
    end else if (lba_capable) begin
      lba_bytes[2:0] = addr[23:0];
      head = addr[27:24];
      dev_base = DEVSEL_LBA;
      opcode = r.is_write ? CMD_WRITE_PIO : CMD_READ_PIO;
    end else begin
      // Fixed geometry; the cylinder keeps only its low 16 bits
      track_no = addr / TRACK_SECTORS;
      sector_no = addr % TRACK_SECTORS + 48'd1;
      cylinder = track_no / HEADS;
      head = track_no[3:0];
      lba_bytes[0] = sector_no[7:0];
      lba_bytes[1] = cylinder[7:0];
      lba_bytes[2] = cylinder[15:8];
      dev_base = DEVSEL_CHS;
      opcode = r.is_write ? CMD_WRITE_PIO : CMD_READ_PIO;
    end
    push_write(SEL_DEVSEL, dev_base | {3'b000, slave_sel, head}, 1'b0);
    push_write(SEL_FEATURES, 8'h00, 1'b0);
    if (ext) begin
      push_write(SEL_COUNT_HI, 8'h00, 1'b0);
      push_write(SEL_LBA3, lba_bytes[3], 1'b0);
      push_write(SEL_LBA4, lba_bytes[4], 1'b0);
      push_write(SEL_LBA5, lba_bytes[5], 1'b0);
    end
    push_write(SEL_COUNT_LO, r.sector_count[7:0], 1'b0);
    push_write(SEL_LBA0, lba_bytes[0], 1'b0);
    push_write(SEL_LBA1, lba_bytes[1], 1'b0);
    push_write(SEL_LBA2, lba_bytes[2], 1'b0);
    push_write(SEL_COMMAND, opcode, 1'b1);
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      error_count++;
    end
  endfunction

  // Compare every accepted write with the oldest one owed
  always @(posedge clk) begin : check_writes
    wr_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: reg_select 0x%0h reg_value 0x%0h status %0b last %0b",
               out_data.reg_select, out_data.reg_value, out_data.status, out_data.last);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        check_field("reg_select", 32'(want.reg_select), 32'(out_data.reg_select));
        check_field("reg_value", 32'(want.reg_value), 32'(out_data.reg_value));
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Receiver: steady, random or periodic stalls, plus a long hold-off on demand
  initial begin : receiver
    rx_pace_t    rx_mode;
    int unsigned mode_left;
    int unsigned tick;
    logic        ready_next;
    out_ready = 1'b0;
    rx_mode = RX_STEADY;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        rx_mode = rx_pace_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      case (rx_mode)
        RX_STEADY:   ready_next = 1'b1;
        RX_RANDOM:   ready_next = ($urandom_range(0, 2) != 0);
        default:     ready_next = (tick % 5 < 3);
      endcase
      out_ready <= ready_next;
    end
  end

  // Drop valid and hold until every owed write has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] index, logic [0:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
  endtask

  // Reprogram both registers once the block has gone quiet
  task automatic apply_setting(logic slave, logic has_lba);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(CFG_DRIVE_SLAVE, slave);
    write_register(CFG_HAS_LBA, has_lba);
    @(negedge clk);
    cfg_write <= 1'b0;
    slave_sel = slave;
    lba_capable = has_lba;
  endtask

  // Send requests in bursts with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_request(req_t r);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Overall time limit
  initial begin
    #1_000_000;
    $display("ata_taskfile_setup verification failed");
    $finish;
  end

  initial begin : stimulus
    req_t        r;
    logic [63:0] wide;
    int unsigned pick;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_DRIVE_SLAVE;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    slave_sel = 1'b0;
    lba_capable = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table, reprogramming only where a row asks for it
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (stim_table[i].slave != slave_sel || stim_table[i].has_lba != lba_capable)
        apply_setting(stim_table[i].slave, stim_table[i].has_lba);
      pace_sender();
      send_request(stim_table[i].req);
      if (stim_table[i].typed)
        pending_writes.push_back(stim_table[i].typed_write);
      else
        predict_taskfile_writes(stim_table[i].req);
    end

    // Random requests over several register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(PHASE_SLAVE[p], PHASE_LBA[p]);
      // Hold the receiver off while requests keep coming, so the block backs up
      if (p == 1 || p == 3)
        long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 2 && n == PHASE_REQUESTS / 2)
          wait_drained();
        wide = {$urandom(), $urandom()};
        pick = $urandom_range(0, 99);
        if (pick < 30)
          r.block_address = wide[47:0];
        else if (pick < 60)
          r.block_address = {20'h0, wide[27:0]};
        else if (pick < 75)
          r.block_address = 48'h0000_0FFF_FFFE + 48'($urandom_range(0, 3));
        else if (pick < 90)
          r.block_address = 48'($urandom_range(0, 5000));
        else
          r.block_address = 48'd66060286 + 48'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 5)
          r.sector_count = 9'd0;
        else if (pick < 12)
          r.sector_count = 9'($urandom_range(256, 511));
        else if (pick < 18)
          r.sector_count = ($urandom_range(0, 1) != 0) ? 9'd1 : 9'd255;
        else
          r.sector_count = 9'($urandom_range(1, 255));
        r.is_write = 1'($urandom_range(0, 1));
        pace_sender();
        send_request(r);
        predict_taskfile_writes(r);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("ata_taskfile_setup verification clean");
    else
      $display("ata_taskfile_setup verification failed");
    $finish;
  end

endmodule
